// ----- hdl/indexed_list_insert_remove_defines.svh -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_defines.svh
// Assertion macros shared by the indexed list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication
`define ILIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilir: implication check failed");

// next-cycle implication
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilir: next-cycle check failed");

// invariant on every edge
`define ILIR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ilir: invariant check failed");

`endif

// ----- hdl/ilir_pkg.sv -----
// ----------------------------------------------------------------------------
// ilir_pkg
// Types and codes for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [6:0]  position;
        logic [31:0] data_in;
    } t_in;

    typedef struct packed {
        logic [31:0] data_out;
        logic [6:0]  entry_count;
        t_status     status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_UP,
        S_PUT,
        S_DN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic check;
        logic rd_pos;
        logic start_up;
        logic step_up;
        logic put;
        logic capture;
        logic set_wr;
        logic start_dn;
        logic step_dn;
        logic dec;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        t_op  op;
        logic pos_eq_count;
        logic pos_last;
        logic cur_at_pos;
        logic cur_at_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/indexed_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Fixed-capacity ordered list: insert, remove, get and set/append by index.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in  (operation, position,
//          |     |                           |        data_in)
//  out     | out | o_out_valid / i_out_ready | o_out (data_out, entry_count,
//          |     |                           |        status)
//
//  One request at a time. Errors, append and insert at the tail go from check
//  to result; get, set and remove read the entry first; insert and remove
//  shift the entries from p on, one moved per cycle through the entry memory
//  (one read, one write port). Reset clears count, output valid and state.
//  A result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ilir_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ilir_pkg::t_out      o_out
);

    ilir_pkg::t_cmd  cmd;
    ilir_pkg::t_stat stat;

    ilir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ilir_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // failed operations never return data
    `ILIR_ASSERT_IMPL(a_err_no_data, i_clk, i_rst_n,
        o_out_valid && o_out.status != ilir_pkg::ST_OK, o_out.data_out == 32'd0)

    // busy right after a request is taken
    `ILIR_ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, cmd.load, !o_in_ready)

    // one memory write port
    `ILIR_ASSERT_ALWAYS(a_one_write, i_clk, i_rst_n,
        $onehot0({cmd.put, cmd.set_wr, cmd.step_up, cmd.step_dn}))

endmodule

`default_nettype wire

// ----- hdl/ilir_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilir_ctrl
// Sequencer for the list operations: check, read, shift loops, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ilir_pkg::t_stat i_stat,
    output ilir_pkg::t_cmd       o_cmd
);

    ilir_pkg::t_state r_state;
    ilir_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilir_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ilir_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ilir_pkg::S_CHECK;
                end
            end
            ilir_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.err) begin
                    n_state = ilir_pkg::S_DONE;
                end else begin
                    unique case (i_stat.op)
                        ilir_pkg::OP_GET, ilir_pkg::OP_REMOVE: begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = ilir_pkg::S_READ;
                        end
                        ilir_pkg::OP_SET: begin
                            if (i_stat.pos_eq_count) begin
                                o_cmd.put = 1'b1;
                                n_state   = ilir_pkg::S_DONE;
                            end else begin
                                o_cmd.rd_pos = 1'b1;
                                n_state      = ilir_pkg::S_READ;
                            end
                        end
                        default: begin
                            // insert at the tail needs no shift
                            if (i_stat.pos_eq_count) begin
                                o_cmd.put = 1'b1;
                                n_state   = ilir_pkg::S_DONE;
                            end else begin
                                o_cmd.start_up = 1'b1;
                                n_state        = ilir_pkg::S_UP;
                            end
                        end
                    endcase
                end
            end
            ilir_pkg::S_READ: begin
                o_cmd.capture = 1'b1;
                unique case (i_stat.op)
                    ilir_pkg::OP_SET: begin
                        o_cmd.set_wr = 1'b1;
                        n_state      = ilir_pkg::S_DONE;
                    end
                    ilir_pkg::OP_REMOVE: begin
                        if (i_stat.pos_last) begin
                            o_cmd.dec = 1'b1;
                            n_state   = ilir_pkg::S_DONE;
                        end else begin
                            o_cmd.start_dn = 1'b1;
                            n_state        = ilir_pkg::S_DN;
                        end
                    end
                    default: begin
                        n_state = ilir_pkg::S_DONE;
                    end
                endcase
            end
            ilir_pkg::S_UP: begin
                o_cmd.step_up = 1'b1;
                if (i_stat.cur_at_pos) begin
                    n_state = ilir_pkg::S_PUT;
                end
            end
            ilir_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = ilir_pkg::S_DONE;
            end
            ilir_pkg::S_DN: begin
                o_cmd.step_dn = 1'b1;
                if (i_stat.cur_at_last) begin
                    o_cmd.dec = 1'b1;
                    n_state   = ilir_pkg::S_DONE;
                end
            end
            ilir_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ilir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilir_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ilir_dpath.sv -----
// ----------------------------------------------------------------------------
// ilir_dpath
// Entry memory, count, shift cursor, status decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_dpath #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ilir_pkg::t_in  i_in,
    input  wire ilir_pkg::t_cmd i_cmd,
    output ilir_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ilir_pkg::t_out      o_out
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    ilir_pkg::t_op          r_op;
    logic [6:0]             r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_cursor;
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic [VALUE_WIDTH-1:0] r_res_data;
    ilir_pkg::t_status      r_res_status;
    logic                   r_out_valid;
    ilir_pkg::t_out         r_out;

    logic [CMPW-1:0]        pos_c;
    logic [CMPW-1:0]        cnt_c;
    logic [CMPW-1:0]        cur_c;
    logic                   full;
    ilir_pkg::t_status      status;
    logic [AW-1:0]          pos_a;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    assign pos_c = CMPW'(r_pos);
    assign cnt_c = CMPW'(r_count);
    assign cur_c = CMPW'(r_cursor);
    assign full  = (r_count == CW'(CAPACITY));
    assign pos_a = AW'(r_pos);

    // error decode; empty wins over range on remove
    always_comb begin
        status = ilir_pkg::ST_OK;
        unique case (r_op)
            ilir_pkg::OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    status = ilir_pkg::ST_RANGE;
                end else if (full) begin
                    status = ilir_pkg::ST_FULL;
                end
            end
            ilir_pkg::OP_REMOVE: begin
                if (r_count == '0) begin
                    status = ilir_pkg::ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    status = ilir_pkg::ST_RANGE;
                end
            end
            ilir_pkg::OP_GET: begin
                if (pos_c >= cnt_c) begin
                    status = ilir_pkg::ST_RANGE;
                end
            end
            default: begin
                if (pos_c > cnt_c) begin
                    status = ilir_pkg::ST_RANGE;
                end else if (pos_c == cnt_c && full) begin
                    status = ilir_pkg::ST_FULL;
                end
            end
        endcase
    end

    always_comb begin
        o_stat.err          = (status != ilir_pkg::ST_OK);
        o_stat.op           = r_op;
        o_stat.pos_eq_count = (pos_c == cnt_c);
        o_stat.pos_last     = ((pos_c + CMPW'(1)) == cnt_c);
        o_stat.cur_at_pos   = (cur_c == pos_c);
        o_stat.cur_at_last  = ((cur_c + CMPW'(1)) == cnt_c);
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    // single read port; the loop steps skip the read past their last entry
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = pos_a;
        if (i_cmd.rd_pos) begin
            rd_en   = 1'b1;
            rd_addr = pos_a;
        end else if (i_cmd.start_up) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_count - CW'(1));
        end else if (i_cmd.start_dn) begin
            rd_en   = 1'b1;
            rd_addr = pos_a + AW'(1);
        end else if (i_cmd.step_up) begin
            rd_en   = !o_stat.cur_at_pos;
            rd_addr = r_cursor - AW'(1);
        end else if (i_cmd.step_dn) begin
            rd_en   = !o_stat.cur_at_last;
            rd_addr = r_cursor + AW'(1);
        end
    end

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_a;
        wr_data = r_val;
        if (i_cmd.put || i_cmd.set_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.step_up) begin
            wr_en   = 1'b1;
            wr_addr = r_cursor + AW'(1);
            wr_data = r_rdata;
        end else if (i_cmd.step_dn) begin
            wr_en   = 1'b1;
            wr_addr = r_cursor - AW'(1);
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in.operation;
            r_pos <= i_in.position;
            r_val <= VALUE_WIDTH'(i_in.data_in);
        end
        if (i_cmd.start_up) begin
            r_cursor <= AW'(r_count - CW'(1));
        end else if (i_cmd.start_dn) begin
            r_cursor <= pos_a + AW'(1);
        end else if (i_cmd.step_up) begin
            r_cursor <= r_cursor - AW'(1);
        end else if (i_cmd.step_dn) begin
            r_cursor <= r_cursor + AW'(1);
        end
        if (i_cmd.check) begin
            r_res_data   <= '0;
            r_res_status <= status;
        end else if (i_cmd.capture) begin
            r_res_data <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_out.data_out    <= 32'(r_res_data);
            r_out.entry_count <= 7'(r_count);
            r_out.status      <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
